// ===== hdl/eacc_pkg.sv =====
// Shared types and constants for the encoder angle check and correction block.
package eacc_pkg;

    // Angle decode
    localparam int ANGLE_W     = 13;
    localparam int ANGLE_TICKS = 8192;
    localparam int WORD_W      = 16;
    localparam int WORD_SHIFT  = 3;

    // Correction table (entry count is a power of two, indices wrap)
    localparam int SEGMENT_BITS  = 6;
    localparam int TABLE_ENTRIES = 128;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int INDEX_W       = 7;
    localparam int OFFSET_W      = 16;

    // Interpolation arithmetic
    localparam int DIFF_W = OFFSET_W + 1;
    localparam int FRAC_W = SEGMENT_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_W;

    // Jump check arithmetic, wide enough for +/- (limit + one turn)
    localparam int DELTA_W = ANGLE_W + 3;

    localparam logic [ANGLE_W-1:0] JUMP_LIMIT_RESET = ANGLE_W'(1365);

    // Item kinds carried in the mode field
    localparam logic MODE_SAMPLE      = 1'b0;
    localparam logic MODE_TABLE_WRITE = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [WORD_W-1:0]          spi_word;
        logic                       check_jump;
        logic [INDEX_W-1:0]         table_index;
        logic signed [OFFSET_W-1:0] table_offset;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]         raw_angle;
        logic signed [OFFSET_W-1:0] corrected_angle;
        logic                       unstable;
    } out_item_t;

endpackage

// ===== hdl/eacc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module eacc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/encoder_angle_check_and_correct.sv =====
// Top level: sensor angle decode, jump check and table-interpolated correction.
// A sample item's result passes three register stages (stage 1 loaded at its acceptance edge,
// then stage 2 and the output register) before it is on out_valid.
// Throughput: one item per cycle while in_stall is low; the offset table is in two RAM copies
// so both neighbor entries are read in the acceptance cycle; a table write lands then.
// Reset (rst_n, async, active low): pipeline empties, jump_limit = 1365, previous angle = 0 and
// all table entries read as zero through per-entry valid bits; no clearing pass is needed.
module encoder_angle_check_and_correct (
    input  logic                     clk,
    input  logic                     rst_n,
    // Sample / table-write items
    input  logic                     in_valid,
    output logic                     in_stall,
    input  eacc_pkg::in_item_t       in_data,
    // Results
    output logic                     out_valid,
    input  logic                     out_stall,
    output eacc_pkg::out_item_t      out_data,
    // jump_limit register write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [eacc_pkg::ANGLE_W-1:0] cfg_data
);
    import eacc_pkg::*;

    // ------------------------------------------------------------------
    // Handshake and stage enables. Each stage moves when it is empty or
    // when the stage after it moves, so bubbles collapse and the input
    // keeps flowing into empty stages while a finished result waits in
    // the output register.
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_en, s2_en, s1_en;
    logic in_accept, sample_accept, write_accept;

    assign out_en   = !out_valid_reg || !out_stall;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (in_data.mode == MODE_SAMPLE);
    assign write_accept  = in_accept && (in_data.mode == MODE_TABLE_WRITE) &&
                           (32'(in_data.table_index) < TABLE_ENTRIES);

    // ------------------------------------------------------------------
    // Configuration: always ready, the only register is jump_limit.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] jump_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_limit_reg <= JUMP_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            jump_limit_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Acceptance cycle: decode the angle, run the jump check against the
    // previous angle and issue both table reads.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]       angle;
    logic [ANGLE_W-1:0]       previous_angle_reg;
    logic [ANGLE_W-1:0]       seg_full;
    logic [TABLE_AW-1:0]      seg_lo, seg_hi;
    logic [SEGMENT_BITS-1:0]  frac;
    logic signed [DELTA_W-1:0] delta, lim, ticks;
    logic                     jump_c1, jump_c2, jump_c3, unstable_now;

    assign angle    = ANGLE_W'(in_data.spi_word >> WORD_SHIFT);
    assign seg_full = angle >> SEGMENT_BITS;
    assign seg_lo   = seg_full[TABLE_AW-1:0];
    assign seg_hi   = seg_lo + TABLE_AW'(1);   // wraps at the table end
    assign frac     = angle[SEGMENT_BITS-1:0];

    // A jump is too large only if it also fails after adding or removing one turn.
    assign delta = DELTA_W'($signed({1'b0, previous_angle_reg})) -
                   DELTA_W'($signed({1'b0, angle}));
    assign lim   = DELTA_W'($signed({1'b0, jump_limit_reg}));
    assign ticks = DELTA_W'(ANGLE_TICKS);

    always_comb
    begin
        jump_c1      = (delta > lim) || (delta < -lim);
        jump_c2      = (delta > lim + ticks) || (delta < ticks - lim);
        jump_c3      = (delta > lim - ticks) || (delta < -lim - ticks);
        unstable_now = in_data.check_jump && jump_c1 && jump_c2 && jump_c3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_angle_reg <= '0;
        end
        else if (sample_accept)
        begin
            previous_angle_reg <= angle;
        end
    end

    // Per-entry valid bits: an entry never written reads as zero.
    logic [TABLE_ENTRIES-1:0] tbl_valid_reg;
    logic [TABLE_AW-1:0]      wr_addr;

    assign wr_addr = in_data.table_index[TABLE_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (write_accept)
        begin
            tbl_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Two copies of the table, written together, one read port each.
    // A write lands at its acceptance edge, so the next item already sees it.
    logic [OFFSET_W-1:0] rd_lo, rd_hi;

    eacc_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram_lo (
        .clk     (clk),
        .wr_en   (write_accept),
        .wr_addr (wr_addr),
        .wr_data (in_data.table_offset),
        .rd_en   (sample_accept),
        .rd_addr (seg_lo),
        .rd_data (rd_lo)
    );

    eacc_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram_hi (
        .clk     (clk),
        .wr_en   (write_accept),
        .wr_addr (wr_addr),
        .wr_data (in_data.table_offset),
        .rd_en   (sample_accept),
        .rd_addr (seg_hi),
        .rd_data (rd_hi)
    );

    // ------------------------------------------------------------------
    // Stage 1: table data arrives; form (b - a) * frac.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]      s1_angle_reg;
    logic [SEGMENT_BITS-1:0] s1_frac_reg;
    logic                    s1_unstable_reg;
    logic                    s1_lo_ok_reg, s1_hi_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= sample_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_angle_reg    <= angle;
            s1_frac_reg     <= frac;
            s1_unstable_reg <= unstable_now;
            s1_lo_ok_reg    <= tbl_valid_reg[seg_lo];
            s1_hi_ok_reg    <= tbl_valid_reg[seg_hi];
        end
    end

    logic signed [OFFSET_W-1:0] s1_a, s1_b;
    logic signed [DIFF_W-1:0]   s1_diff;
    logic signed [FRAC_W-1:0]   s1_frac_s;
    logic signed [PROD_W-1:0]   s1_prod;

    always_comb
    begin
        s1_a      = s1_lo_ok_reg ? $signed(rd_lo) : '0;
        s1_b      = s1_hi_ok_reg ? $signed(rd_hi) : '0;
        s1_diff   = DIFF_W'(s1_b) - DIFF_W'(s1_a);
        s1_frac_s = $signed({1'b0, s1_frac_reg});
        s1_prod   = PROD_W'(s1_diff) * PROD_W'(s1_frac_s);
    end

    // ------------------------------------------------------------------
    // Stage 2: hold the product; floor-shift and sum into the output.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]         s2_angle_reg;
    logic                       s2_unstable_reg;
    logic signed [OFFSET_W-1:0] s2_a_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_angle_reg    <= s1_angle_reg;
            s2_unstable_reg <= s1_unstable_reg;
            s2_a_reg        <= s1_a;
            s2_prod_reg     <= s1_prod;
        end
    end

    // Arithmetic shift right is the floor division; the sum wraps to 16 bits.
    logic signed [PROD_W-1:0] s2_step;
    logic [OFFSET_W-1:0]      s2_corr;

    always_comb
    begin
        s2_step = s2_prod_reg >>> SEGMENT_BITS;
        s2_corr = OFFSET_W'(s2_angle_reg) + OFFSET_W'(s2_a_reg) + s2_step[OFFSET_W-1:0];
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled.
    // ------------------------------------------------------------------
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid_reg)
        begin
            out_data_reg.raw_angle       <= s2_angle_reg;
            out_data_reg.corrected_angle <= $signed(s2_corr);
            out_data_reg.unstable        <= s2_unstable_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/eacc_sva.sv =====
// Port-level checks for the encoder angle check and correction block, with bind.
module eacc_sva (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input eacc_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input eacc_pkg::out_item_t out_data
);
    import eacc_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

    // With the output moving, the input is never stalled.
    a_no_stall_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // A sample result reaches out_valid when the output is not stalled after the sample's acceptance.
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.mode == MODE_SAMPLE)
            ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("sample result late");

endmodule

bind encoder_angle_check_and_correct eacc_sva u_eacc_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/angle_correction_checker.sv =====
// Checker for the encoder angle block: predicts decoded, corrected angles and compares results.
`timescale 1ns / 100ps

module angle_correction_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  eacc_pkg::in_item_t            in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  eacc_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [eacc_pkg::ANGLE_W-1:0]  cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import eacc_pkg::*;

    // Own copy of the block state
    logic [ANGLE_W-1:0]         limit_copy;
    logic [ANGLE_W-1:0]         last_angle_copy;
    logic signed [OFFSET_W-1:0] offset_copy [TABLE_ENTRIES];

    out_item_t expected_angles [$];

    // Several fields can miss in one cycle, so count immediately
    task automatic report_mismatch(input string what, input logic [OFFSET_W-1:0] got,
                                   input logic [OFFSET_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Decode, jump check against the stored angle, and table interpolation
    function automatic out_item_t predict_correction(input in_item_t item);
        logic [ANGLE_W-1:0]      angle;
        logic [TABLE_AW-1:0]     seg;
        logic [TABLE_AW-1:0]     seg_next;
        logic [SEGMENT_BITS-1:0] frac;
        int                      lo_entry;
        int                      hi_entry;
        int                      slope;
        int                      delta;
        int                      lim;
        out_item_t               res;
        angle    = item.spi_word[WORD_W-1:WORD_SHIFT];
        seg      = angle[ANGLE_W-1:SEGMENT_BITS];
        seg_next = seg + 1'b1;
        frac     = angle[SEGMENT_BITS-1:0];
        lo_entry = offset_copy[seg];
        hi_entry = offset_copy[seg_next];
        slope    = (hi_entry - lo_entry) * int'(frac);
        res.raw_angle       = angle;
        res.corrected_angle = OFFSET_W'(int'(angle) + lo_entry + (slope >>> SEGMENT_BITS));
        res.unstable        = 1'b0;
        if (item.check_jump) begin
            delta = int'(last_angle_copy) - int'(angle);
            lim   = int'(limit_copy);
            // too large directly, one turn up and one turn down
            res.unstable = (delta > lim || delta < -lim)
                        && (delta > lim + ANGLE_TICKS || delta < ANGLE_TICKS - lim)
                        && (delta > lim - ANGLE_TICKS || delta < -lim - ANGLE_TICKS);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            limit_copy      <= JUMP_LIMIT_RESET;
            last_angle_copy <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                offset_copy[i] <= '0;
            expected_angles.delete();
            mismatches   = 0;
            outstanding <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("result with no sample waiting",
                                    out_data.corrected_angle, '0);
                end else begin
                    want = expected_angles.pop_front();
                    if (out_data.raw_angle !== want.raw_angle)
                        report_mismatch("raw_angle", OFFSET_W'(out_data.raw_angle),
                                        OFFSET_W'(want.raw_angle));
                    if (out_data.corrected_angle !== want.corrected_angle)
                        report_mismatch("corrected_angle", out_data.corrected_angle,
                                        want.corrected_angle);
                    if (out_data.unstable !== want.unstable)
                        report_mismatch("unstable", OFFSET_W'(out_data.unstable),
                                        OFFSET_W'(want.unstable));
                end
            end
            if (cfg_valid && cfg_ready)
                limit_copy <= cfg_data;
            if (in_valid && !in_stall) begin
                if (in_data.mode == MODE_TABLE_WRITE) begin
                    offset_copy[in_data.table_index] <= in_data.table_offset;
                end else begin
                    expected_angles.push_back(predict_correction(in_data));
                    last_angle_copy <= in_data.spi_word[WORD_W-1:WORD_SHIFT];
                end
            end
            outstanding <= expected_angles.size();
        end
    end

endmodule

// ===== sim/encoder_angle_check_and_correct_tb.sv =====
// Testbench top for the encoder angle check and correction block: stimulus and verdict.
`timescale 1ns / 100ps

module encoder_angle_check_and_correct_tb;
    import eacc_pkg::*;

    localparam int PHASE_ITEMS = 200;
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
    localparam int SETTLE      = 8;        // covers the pipeline plus a margin
    localparam int CYCLE_LIMIT = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ANGLE_W-1:0]   cfg_data = '0;

    int                   mismatches;
    int                   outstanding;
    int                   cycle_count = 0;

    // noise_on and holds_asked are shared between the sender and receiver processes
    logic                 noise_on = 1'b1;
    int                   holds_asked = 0;
    int                   holds_done = 0;
    int                   hold_left = 0;

    // Stimulus-side tracking, only used to aim jumps near the limit
    logic [ANGLE_W-1:0]   last_angle = '0;
    logic [ANGLE_W-1:0]   current_limit = JUMP_LIMIT_RESET;

    always #6 clk = ~clk;

    encoder_angle_check_and_correct dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    angle_correction_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks
    // for one. The hold is counted here so the sender keeps offering items
    // meanwhile and the pipeline backs up into in_stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= LONG_HOLD;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= noise_on && ($urandom_range(99) < 24);
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("encoder_angle_check_and_correct_tb: errors");
            $finish;
        end
    end

    // Offer one item, with random idle cycles ahead of it, and hold it
    // until the block takes it. Returns at the accepting edge.
    task automatic send_item(input in_item_t item);
        while (noise_on && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Angle sample; the table fields are don't-care but still get random bits
    task automatic send_sample(input logic [ANGLE_W-1:0] angle, input logic check);
        in_item_t item;
        item.mode         = MODE_SAMPLE;
        item.spi_word     = {angle, WORD_SHIFT'($urandom)};
        item.check_jump   = check;
        item.table_index  = INDEX_W'($urandom);
        item.table_offset = OFFSET_W'($urandom);
        last_angle = angle;
        send_item(item);
    endtask

    // Table write; the sample fields are don't-care but still get random bits
    task automatic send_table_write(input logic [INDEX_W-1:0] idx,
                                    input logic signed [OFFSET_W-1:0] offset);
        in_item_t item;
        item.mode         = MODE_TABLE_WRITE;
        item.spi_word     = WORD_W'($urandom);
        item.check_jump   = 1'($urandom);
        item.table_index  = idx;
        item.table_offset = offset;
        send_item(item);
    endtask

    // Drop valid and hold until every result is in; table writes leave no
    // result and land at their acceptance edge; SETTLE adds a margin.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_jump_limit(input logic [ANGLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        current_limit = value;
    endtask

    // One random item: mostly samples aimed at the jump limit and the
    // table wrap, some table writes with extreme or random offsets.
    task automatic send_random_item();
        logic [ANGLE_W-1:0]          angle;
        logic [ANGLE_W-1:0]          step;
        logic signed [OFFSET_W-1:0]  offset;
        logic                        check;
        int                          pick;
        pick  = $urandom_range(99);
        check = ($urandom_range(9) != 0);
        if (pick < 20) begin
            case ($urandom_range(7))
                0:       offset = 16'sh7FFF;
                1:       offset = 16'sh8000;
                2:       offset = '0;
                3:       offset = -16'sd1;
                default: offset = OFFSET_W'($urandom);
            endcase
            send_table_write(INDEX_W'($urandom), offset);
        end else begin
            case ($urandom_range(3))
                0: angle = ANGLE_W'($urandom);
                1: begin
                    // right at the limit, one below or one above
                    step  = current_limit + ANGLE_W'($urandom_range(2)) - 1'b1;
                    angle = $urandom_range(1) ? last_angle + step : last_angle - step;
                end
                2: begin
                    step  = ANGLE_W'($urandom_range(int'(current_limit)));
                    angle = $urandom_range(1) ? last_angle + step : last_angle - step;
                end
                default: angle = $urandom_range(1) ? ANGLE_W'($urandom_range(7))
                                                   : ANGLE_W'(ANGLE_TICKS - 1 -
                                                              $urandom_range(7));
            endcase
            send_sample(angle, check);
        end
    endtask

    initial begin
        logic [ANGLE_W-1:0] limit_plan [7];
        limit_plan[0] = JUMP_LIMIT_RESET;   // reset value, not written
        limit_plan[1] = '0;
        limit_plan[2] = '1;
        limit_plan[3] = ANGLE_W'(1);
        limit_plan[4] = ANGLE_W'($urandom);
        limit_plan[5] = ANGLE_W'(4096);
        limit_plan[6] = ANGLE_W'(2730);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first sample after reset compares against zero
        send_sample('0, 1'b1);
        // full-scale angle is one tick from zero across the wrap: stable
        send_sample('1, 1'b1);
        // half a turn away: unstable
        send_sample(ANGLE_W'(4096), 1'b1);
        // large jump with checking off: never flagged, angle still tracked
        send_sample('0, 1'b0);

        // Extreme offsets on both sides of the table wrap and mid-table
        send_table_write(INDEX_W'(0), 16'sh7FFF);
        send_table_write(INDEX_W'(1), 16'sh8000);
        send_table_write(INDEX_W'(127), -16'sd1);
        send_table_write(INDEX_W'(64), 16'sd12345);
        send_table_write(INDEX_W'(63), -16'sd20000);

        send_sample(ANGLE_W'(0), 1'b1);
        send_sample(ANGLE_W'(32), 1'b1);
        send_sample(ANGLE_W'(63), 1'b1);        // largest fraction
        send_sample(ANGLE_W'(64), 1'b1);
        send_sample(ANGLE_W'(4095), 1'b1);
        send_sample(ANGLE_W'(4096), 1'b1);
        send_sample(ANGLE_W'(8160), 1'b1);
        send_sample('1, 1'b1);                   // last segment reads entry 0
        send_table_write(INDEX_W'(127), 16'sh7FFF);
        send_sample('1, 1'b1);                   // same angle after the rewrite

        // Jump exactly the limit across the wrap, then one past it
        send_sample(ANGLE_W'(1364), 1'b1);
        send_sample(ANGLE_W'(2730), 1'b1);
        drain_results();

        for (int phase = 0; phase < 7; phase++) begin
            if (phase != 0)
                write_jump_limit(limit_plan[phase]);
            // a long stretch with no idling on either side
            noise_on = (phase != 3);
            if (phase == 2)
                holds_asked = holds_asked + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pause the sender mid-phase until every result is in
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_random_item();
            end
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("encoder_angle_check_and_correct_tb: clean");
        else
            $display("encoder_angle_check_and_correct_tb: errors");
        $finish;
    end

endmodule
